// ===== rtl/dst_pkg.sv =====
`default_nettype none
// ============================================================================
// dst_pkg
// Shared types, codes and character helpers of the distinguished-name
// string tokenizer.
// ============================================================================
package dst_pkg;

    localparam logic [15:0] LEN_CAP  = 16'hFFFF;
    localparam logic [7:0]  PART_CAP = 8'hFF;
    localparam logic [15:0] SPACE_CAP = 16'hFFFF;

    localparam int MAX_RES   = 3;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] K_NAME    = 3'd0;
    localparam logic [2:0] K_VALUE   = 3'd1;
    localparam logic [2:0] K_NAMEEND = 3'd2;
    localparam logic [2:0] K_PARTEND = 3'd3;
    localparam logic [2:0] K_DONE    = 3'd4;
    localparam logic [2:0] K_ERROR   = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        M_BETWEEN  = 3'd0,
        M_NAME     = 3'd1,
        M_PREVAL   = 3'd2,
        M_UNQUOTED = 3'd3,
        M_QUOTED   = 3'd4,
        M_AFTERQ   = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] trim_count;
        logic [7:0]  part_number;
        logic [15:0] consumed;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]       cnt;
        token_t [MAX_RES-1:0]       res;
    } bundle_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return b inside {CH_COMMA, CH_SEMI};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // '0'..'9' low nibble is the value; 'A'..'F' and 'a'..'f' low nibble is 1..6
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        return is_digit(b) ? b[3:0] : b[3:0] + 4'd9;
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        return b inside {CH_DQUOTE, CH_BSLASH, CH_COMMA, CH_PLUS, CH_LT,
                         CH_GT, CH_SEMI, CH_SPACE, CH_HASH};
    endfunction

    function automatic token_t mk_tok(input logic [2:0]  kind,
                                      input logic [7:0]  b,
                                      input logic [15:0] trim,
                                      input logic [7:0]  pn,
                                      input logic [15:0] cons,
                                      input logic        last);
        token_t t;
        t.kind        = kind;
        t.out_byte    = b;
        t.trim_count  = trim;
        t.part_number = pn;
        t.consumed    = cons;
        t.last        = last;
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dn_string_tokenizer.sv =====
`default_nettype none
// ============================================================================
// dn_string_tokenizer
// Distinguished-name string tokenizer.
//
// Input channel (byte_*): one raw byte per request with a last-byte mark.
// Output channel (token_*): decoded name/value bytes, name-end and part-end
// markers, and one final done or error token per string (last = 1).
// Both channels: a request moves on a rising edge with valid high and stall
// low.
// An accepted byte's tokens pass through the queue, then the output register.
// Throughput: one byte per cycle when no byte yields more than one token
// and token_stall stays low. A byte yielding two or three tokens sends them
// one at a time; the four-bundle queue absorbs bursts before byte_stall rises.
// Receiver stall: the output register holds its token, the queue fills,
// then byte_stall goes high; nothing is dropped.
// Reset: parse state clears to between parts, queue and output empty.
// Each string is parsed on its own; state clears after its last byte.
// ============================================================================
module dn_string_tokenizer
    import dst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_item_t byte_data,
    output logic            token_valid,
    input  wire logic       token_stall,
    output token_t          token_data
);

    logic    q_full;
    logic    push;
    bundle_t push_data;
    logic    pop;
    logic    head_valid;
    bundle_t head_data;

    assign byte_stall = q_full;

    dst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    dst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    dst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

endmodule
`default_nettype wire

// ===== rtl/dst_front.sv =====
`default_nettype none
// ============================================================================
// dst_front
// Takes one byte per cycle while the queue is not full, advances the parse
// state and builds the bundle of up to three tokens that the byte causes.
// ============================================================================
module dst_front
    import dst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire byte_item_t byte_data,
    input  wire logic       q_full,
    output logic            push,
    output bundle_t         push_data
);

    mode_t       mode_reg, mode_next;
    logic        esc_reg, esc_next;
    logic [3:0]  hnib_reg, hnib_next;
    logic        hhalf_reg, hhalf_next;
    logic [15:0] pend_reg, pend_next;
    logic [7:0]  pc_reg, pc_next;
    logic [15:0] bc_reg, bc_next;
    logic        fail_reg, fail_next;

    logic        accept;
    logic        cap_fault;
    logic        active;
    logic [7:0]  b;
    logic        lst;
    logic [15:0] bc_inc;

    // per-byte decisions
    mode_t       m_tb;
    logic        esc_tb;
    logic [3:0]  hnib_tb;
    logic        hhalf_tb;
    logic [15:0] pend_tb;
    logic        tb_emit;
    logic [2:0]  tb_kind;
    logic [7:0]  tb_byte;
    logic        tb_pe;
    logic [15:0] tb_trim;
    logic        tb_fault;
    logic        fin_fault;
    logic        fin_pe;
    logic [15:0] fin_trim;
    logic        fail_now;

    logic [7:0]  pc_after;
    bundle_t     bundle;

    assign accept    = byte_valid && !q_full;
    assign b         = byte_data.in_byte;
    assign lst       = byte_data.in_last;
    assign cap_fault = (bc_reg == LEN_CAP);
    assign active    = !fail_reg && !cap_fault;
    assign bc_inc    = bc_reg + 16'd1;

    // next parse state
    always_comb
    begin
        logic stop;
        stop     = 1'b0;
        m_tb     = mode_reg;
        esc_tb   = esc_reg;
        hnib_tb  = hnib_reg;
        hhalf_tb = hhalf_reg;
        pend_tb  = pend_reg;
        tb_emit  = 1'b0;
        tb_kind  = K_NAME;
        tb_byte  = b;
        tb_pe    = 1'b0;
        tb_trim  = 16'd0;
        tb_fault = 1'b0;

        if (m_tb == M_BETWEEN)
        begin
            if (is_ws(b))
                stop = 1'b1;
            else
                m_tb = M_NAME;
        end
        if (!stop && m_tb == M_PREVAL)
        begin
            if (is_ws(b))
                stop = 1'b1;
            else
            begin
                pend_tb = 16'd0;
                if (b == CH_DQUOTE)
                begin
                    m_tb = M_QUOTED;
                    stop = 1'b1;
                end
                else
                    m_tb = M_UNQUOTED;
            end
        end
        if (!stop && m_tb == M_AFTERQ)
        begin
            stop = 1'b1;
            if (!is_ws(b))
            begin
                if (is_sep(b))
                    tb_pe = 1'b1;
                else
                    tb_fault = 1'b1;
            end
        end
        if (!stop)
        begin
            if (esc_tb)
            begin
                tb_kind = (m_tb == M_NAME) ? K_NAME : K_VALUE;
                if (hhalf_tb)
                begin
                    if (!is_hex(b))
                        tb_fault = 1'b1;
                    else
                    begin
                        tb_byte  = {hnib_tb, hex_val(b)};
                        hhalf_tb = 1'b0;
                        esc_tb   = 1'b0;
                        tb_emit  = 1'b1;
                    end
                end
                else if (is_special(b))
                begin
                    esc_tb  = 1'b0;
                    tb_emit = 1'b1;
                end
                else if (is_hex(b))
                begin
                    hnib_tb  = hex_val(b);
                    hhalf_tb = 1'b1;
                end
                else
                    tb_fault = 1'b1;
                if (tb_emit)
                    pend_tb = 16'd0;
            end
            else if (b == CH_BSLASH)
            begin
                esc_tb   = 1'b1;
                hhalf_tb = 1'b0;
            end
            else
            begin
                case (m_tb)
                    M_NAME:
                    begin
                        if (b == CH_EQ)
                        begin
                            tb_emit = 1'b1;
                            tb_kind = K_NAMEEND;
                            tb_byte = 8'd0;
                            m_tb    = M_PREVAL;
                        end
                        else if (b < CH_SPACE)
                            tb_fault = 1'b1;
                        else
                        begin
                            tb_emit = 1'b1;
                            tb_kind = K_NAME;
                        end
                    end
                    M_UNQUOTED:
                    begin
                        if (is_sep(b))
                        begin
                            tb_pe   = 1'b1;
                            tb_trim = pend_tb;
                        end
                        else if (b < CH_SPACE)
                            tb_fault = 1'b1;
                        else
                        begin
                            tb_emit = 1'b1;
                            tb_kind = K_VALUE;
                            if (b == CH_SPACE)
                            begin
                                if (pend_tb != SPACE_CAP)
                                    pend_tb = pend_tb + 16'd1;
                            end
                            else
                                pend_tb = 16'd0;
                        end
                    end
                    default:
                    begin
                        if (b == CH_DQUOTE)
                            m_tb = M_AFTERQ;
                        else if (b < CH_SPACE)
                            tb_fault = 1'b1;
                        else
                        begin
                            tb_emit = 1'b1;
                            tb_kind = K_VALUE;
                        end
                    end
                endcase
            end
        end
        if (tb_pe)
        begin
            pend_tb = 16'd0;
            m_tb    = M_BETWEEN;
        end

        // end of string
        fin_fault = 1'b0;
        fin_pe    = 1'b0;
        fin_trim  = 16'd0;
        if (lst && !tb_fault)
        begin
            if (esc_tb || m_tb == M_NAME)
                fin_fault = 1'b1;
            else if (m_tb != M_BETWEEN)
            begin
                fin_pe   = 1'b1;
                fin_trim = (m_tb == M_UNQUOTED) ? pend_tb : 16'd0;
            end
        end

        fail_now = fail_reg || cap_fault || tb_fault || fin_fault;
    end

    // token bundle
    always_comb
    begin
        logic [RES_CNT_W-1:0] n;
        logic [7:0]           pc1;
        n        = '0;
        pc1      = pc_reg;
        bundle   = '0;
        pc_after = pc_reg;
        if (fail_now)
        begin
            if (lst)
            begin
                bundle.res[n[RES_IDX_W-1:0]] =
                    mk_tok(K_ERROR, 8'd0, 16'd0, pc_reg, 16'd0, 1'b1);
                n = n + RES_CNT_W'(1);
            end
        end
        else
        begin
            if (tb_emit)
            begin
                bundle.res[n[RES_IDX_W-1:0]] =
                    mk_tok(tb_kind, tb_byte, 16'd0, pc1, 16'd0, 1'b0);
                n = n + RES_CNT_W'(1);
            end
            if (tb_pe)
            begin
                bundle.res[n[RES_IDX_W-1:0]] =
                    mk_tok(K_PARTEND, 8'd0, tb_trim, pc1, 16'd0, 1'b0);
                n = n + RES_CNT_W'(1);
                if (pc1 < PART_CAP)
                    pc1 = pc1 + 8'd1;
            end
            if (lst)
            begin
                if (fin_pe)
                begin
                    bundle.res[n[RES_IDX_W-1:0]] =
                        mk_tok(K_PARTEND, 8'd0, fin_trim, pc1, 16'd0, 1'b0);
                    n = n + RES_CNT_W'(1);
                    if (pc1 < PART_CAP)
                        pc1 = pc1 + 8'd1;
                end
                bundle.res[n[RES_IDX_W-1:0]] =
                    mk_tok(K_DONE, 8'd0, 16'd0, pc1, bc_inc, 1'b1);
                n = n + RES_CNT_W'(1);
            end
            pc_after = pc1;
        end
        bundle.cnt = n;
    end

    assign push      = accept && (bundle.cnt != '0);
    assign push_data = bundle;

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        hnib_next  = hnib_reg;
        hhalf_next = hhalf_reg;
        pend_next  = pend_reg;
        pc_next    = pc_reg;
        bc_next    = bc_reg;
        fail_next  = fail_reg;
        if (accept)
        begin
            if (lst)
            begin
                mode_next  = M_BETWEEN;
                esc_next   = 1'b0;
                hnib_next  = 4'd0;
                hhalf_next = 1'b0;
                pend_next  = 16'd0;
                pc_next    = 8'd0;
                bc_next    = 16'd0;
                fail_next  = 1'b0;
            end
            else
            begin
                fail_next = fail_now;
                if (active)
                begin
                    mode_next  = m_tb;
                    esc_next   = esc_tb;
                    hnib_next  = hnib_tb;
                    hhalf_next = hhalf_tb;
                    pend_next  = pend_tb;
                    pc_next    = pc_after;
                    bc_next    = bc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_BETWEEN;
            esc_reg   <= 1'b0;
            hnib_reg  <= 4'd0;
            hhalf_reg <= 1'b0;
            pend_reg  <= 16'd0;
            pc_reg    <= 8'd0;
            bc_reg    <= 16'd0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            hnib_reg  <= hnib_next;
            hhalf_reg <= hhalf_next;
            pend_reg  <= pend_next;
            pc_reg    <= pc_next;
            bc_reg    <= bc_next;
            fail_reg  <= fail_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dst_queue.sv =====
`default_nettype none
// ============================================================================
// dst_queue
// Small FIFO of token bundles between the parse front and the output side.
// ============================================================================
module dst_queue
    import dst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output logic         full,
    output logic         head_valid,
    output bundle_t      head_data
);

    bundle_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dst_back.sv =====
`default_nettype none
// ============================================================================
// dst_back
// Walks the head bundle one token at a time into the output register.
// ============================================================================
module dst_back
    import dst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    head_valid,
    input  wire bundle_t head_data,
    output logic         pop,
    output logic         token_valid,
    input  wire logic    token_stall,
    output token_t       token_data
);

    logic                 out_valid_reg, out_valid_next;
    token_t               out_data_reg, out_data_next;
    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 load;
    logic                 tail;

    assign load = head_valid && (!out_valid_reg || !token_stall);
    assign tail = (idx_reg == RES_IDX_W'(head_data.cnt - RES_CNT_W'(1)));
    assign pop  = load && tail;

    always_comb
    begin
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && token_stall;
        if (load)
        begin
            out_data_next  = head_data.res[idx_reg];
            out_valid_next = 1'b1;
            idx_next       = tail ? '0 : idx_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_data  = out_data_reg;

endmodule
`default_nettype wire
